// File: design/assert_macros.svh
// Assertion macros used by the checker file.
// Pure macro header: no code, only defines under an include guard.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while reset is asserted (active low).
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/cmg_pkg.sv
// Types and constants of the cartridge mapper guesser.
// No dependencies; used by the interfaces, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package cmg_pkg;

  localparam int SizeWidth = 25;
  localparam int VoteWidth = 24;
  localparam int NumGroups = 4;

  typedef logic [7:0]           byte_t;
  typedef logic [3:0]           mapper_class_t;
  typedef logic [VoteWidth-1:0] vote_t;
  typedef logic [NumGroups-1:0] vote_mask_t;

  // result codes
  localparam mapper_class_t ClassPlain     = 4'd0;
  localparam mapper_class_t ClassMirrored  = 4'd1;
  localparam mapper_class_t ClassPage2     = 4'd2;
  localparam mapper_class_t ClassSigA      = 4'd3;
  localparam mapper_class_t ClassSigB      = 4'd4;
  localparam mapper_class_t ClassSigC      = 4'd5;
  localparam mapper_class_t ClassGeneric8k = 4'd6;
  localparam mapper_class_t ClassVoteA     = 4'd7;
  localparam mapper_class_t ClassVoteB     = 4'd8;
  localparam mapper_class_t ClassVoteC     = 4'd9;
  localparam mapper_class_t ClassVoteD     = 4'd10;

  // vote group indexes
  localparam int GroupA = 0;
  localparam int GroupB = 1;
  localparam int GroupC = 2;
  localparam int GroupD = 3;

  // configuration register index (paddr[2])
  localparam logic RegImageSize = 1'b0;

  localparam vote_t VoteMax = {VoteWidth{1'b1}};

  localparam byte_t OpStoreAbs = 8'h32;
  localparam byte_t OpReturn   = 8'hC9;
  localparam byte_t HdrA       = 8'h41;
  localparam byte_t HdrB       = 8'h42;

  // header layout
  localparam int HeaderBytes = 4;
  localparam int TextLoPos   = 8;
  localparam int TextHiPos   = 9;
  localparam int VoteMinPos  = 2;
  localparam int SigOffset   = 16;
  localparam int SigEnd      = 24;
  localparam int SigCount    = 3;

  // size thresholds
  localparam int Page2MinSize = 10;
  localparam int Page2MaxSize = 32'h4000;
  localparam int FlatSize     = 32'h10000;

  localparam byte_t SigText [SigCount][8] = '{
    '{8'h41, 8'h53, 8'h43, 8'h49, 8'h49, 8'h31, 8'h36, 8'h58},
    '{8'h52, 8'h4F, 8'h4D, 8'h5F, 8'h4E, 8'h45, 8'h4F, 8'h38},
    '{8'h52, 8'h4F, 8'h4D, 8'h5F, 8'h4E, 8'h45, 8'h31, 8'h36}
  };

  // bank-switch store targets and the groups each one votes for
  function automatic vote_mask_t vote_groups(input logic [15:0] addr);
    vote_mask_t m;
    m = '0;
    unique case (addr)
      16'h5000, 16'h9000, 16'hB000: m[GroupA] = 1'b1;
      16'h4000, 16'h8000, 16'hA000: m[GroupB] = 1'b1;
      16'h6800, 16'h7800:           m[GroupC] = 1'b1;
      16'h6000: begin
        m[GroupB] = 1'b1;
        m[GroupC] = 1'b1;
        m[GroupD] = 1'b1;
      end
      16'h7000: begin
        m[GroupA] = 1'b1;
        m[GroupC] = 1'b1;
        m[GroupD] = 1'b1;
      end
      16'h77FF:                     m[GroupD] = 1'b1;
      default:                      m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// File: design/cmg_in_if.sv
// Input channel of the mapper guesser: one image byte per transaction.
// Depends on cmg_pkg for the byte type.
`timescale 1ns / 1ps
`default_nettype none

interface cmg_in_if;
  logic          valid;
  logic          ready;
  cmg_pkg::byte_t image_byte;
  logic          is_last;

  modport source (output valid, output image_byte, output is_last, input ready);
  modport sink   (input valid, input image_byte, input is_last, output ready);
endinterface

`default_nettype wire

// File: design/cmg_out_if.sv
// Result channel of the mapper guesser: one class code per transaction.
// Depends on cmg_pkg for the class type.
`timescale 1ns / 1ps
`default_nettype none

interface cmg_out_if;
  logic                  valid;
  logic                  ready;
  cmg_pkg::mapper_class_t mapper_class;

  modport source (output valid, output mapper_class, input ready);
  modport sink   (input valid, input mapper_class, output ready);
endinterface

`default_nettype wire

// File: design/cartridge_mapper_guesser.sv
// Cartridge mapper guesser, top level.
// Depends on cmg_pkg, cmg_in_if and cmg_out_if.
//
// Usage:
//   Write image_size (byte address 0, APB, pready tied high) while idle, then
//   stream the image one byte per transaction on in_ch, is_last set on the
//   final byte. Bytes past image_size are ignored. Each is_last transaction
//   yields exactly one mapper_class on out_ch; other bytes yield nothing.
//   A size of zero gives the plain class and ignores the final byte.
// Throughput: one byte per cycle, but an is_last byte waits while out_ch stalls.
// Path: the is_last byte is accepted into the input register; the state update
//   and classifier then feed the output register, which drives out_ch.valid.
//   The classifier works on the updated stream state.
// Stall: out_ch holds its result while ready is low. Bytes without is_last keep
//   flowing; an is_last byte waits in the input register, in_ch.ready low, until
//   the result is taken. No transaction is lost or repeated.
// Reset: rst_n, synchronous active low, clears the stream state, the pending
//   result and image_size; no clearing pass, the block is ready at once.
// MAX_IMAGE_BYTES caps image_size and sets the byte position counter width.
`timescale 1ns / 1ps
`default_nettype none

module cartridge_mapper_guesser #(
  parameter int unsigned MAX_IMAGE_BYTES = 16777216
) (
  input  logic        clk,
  input  logic        rst_n,
  cmg_in_if.sink      in_ch,
  cmg_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PW = $clog2(MAX_IMAGE_BYTES + 1);
  localparam logic [31:0] MaxBytes = 32'(MAX_IMAGE_BYTES);

  typedef logic [PW-1:0] pos_t;

  // configuration
  logic [cmg_pkg::SizeWidth-1:0] size_r;
  logic [31:0]                   size32;
  pos_t                          size_eff;
  pos_t                          size_m1;
  logic                          cfg_wr;

  // input register
  logic           s1_valid_r;
  cmg_pkg::byte_t s1_byte_r;
  logic           s1_last_r;

  // stream state
  pos_t           pos_r, pos_nxt;
  logic [15:0]    prev_r, prev_nxt;
  logic [31:0]    hdr_r, hdr_nxt;
  logic [15:0]    text_r, text_nxt;
  cmg_pkg::byte_t probe_r, probe_nxt;
  logic [cmg_pkg::SigCount-1:0] sigm_r, sigm_nxt;
  cmg_pkg::vote_t votes_r [cmg_pkg::NumGroups];
  cmg_pkg::vote_t votes_nxt [cmg_pkg::NumGroups];

  // output register
  logic                   out_valid_r;
  cmg_pkg::mapper_class_t out_class_r;
  cmg_pkg::mapper_class_t class_nxt;

  logic adv, take, take_byte;
  cmg_pkg::vote_mask_t vmask;
  logic [15:0] idx_cur;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == cmg_pkg::RegImageSize) ? 32'(size_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '0;
    end else if (cfg_wr && paddr[2] == cmg_pkg::RegImageSize) begin
      size_r <= pwdata[cmg_pkg::SizeWidth-1:0];
    end
  end

  assign size32   = 32'(size_r);
  assign size_eff = (size32 > MaxBytes) ? PW'(MaxBytes) : PW'(size32);
  assign size_m1  = size_eff - pos_t'(1);

  // output register is free; only an is_last byte needs it
  assign adv          = !out_valid_r || out_ch.ready;
  assign take         = s1_valid_r && (adv || !s1_last_r);
  assign in_ch.ready  = !s1_valid_r || adv || !s1_last_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.mapper_class = out_class_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.image_byte;
      s1_last_r <= in_ch.is_last;
    end
  end

  assign take_byte = take && (pos_r < size_eff);
  assign idx_cur   = hdr_r[31:16] & size_m1[15:0];
  assign vmask     = cmg_pkg::vote_groups({s1_byte_r, prev_r[7:0]});

  // per-byte state update
  always_comb begin
    pos_nxt   = pos_r;
    prev_nxt  = prev_r;
    hdr_nxt   = hdr_r;
    text_nxt  = text_r;
    probe_nxt = probe_r;
    sigm_nxt  = sigm_r;
    for (int g = 0; g < cmg_pkg::NumGroups; g++) begin
      votes_nxt[g] = votes_r[g];
    end
    if (take_byte) begin
      for (int j = 0; j < cmg_pkg::HeaderBytes; j++) begin
        if (pos_r == PW'(j)) begin
          hdr_nxt[8*j +: 8] = s1_byte_r;
        end
      end
      if (pos_r == PW'(cmg_pkg::TextLoPos)) begin
        text_nxt[7:0] = s1_byte_r;
      end
      if (pos_r == PW'(cmg_pkg::TextHiPos)) begin
        text_nxt[15:8] = s1_byte_r;
      end
      if (pos_r >= PW'(cmg_pkg::SigOffset) && pos_r < PW'(cmg_pkg::SigEnd)) begin
        for (int k = 0; k < cmg_pkg::SigCount; k++) begin
          if (cmg_pkg::SigText[k][pos_r[2:0]] != s1_byte_r) begin
            sigm_nxt[k] = 1'b0;
          end
        end
      end
      if (pos_r >= PW'(cmg_pkg::HeaderBytes) && pos_r == PW'(idx_cur)) begin
        probe_nxt = s1_byte_r;
      end
      // store-absolute opcode two bytes back; must start before size-3
      if (pos_r >= PW'(cmg_pkg::VoteMinPos)
          && ((PW+1)'(pos_r) + (PW+1)'(1)) < (PW+1)'(size_eff)
          && prev_r[15:8] == cmg_pkg::OpStoreAbs) begin
        for (int g = 0; g < cmg_pkg::NumGroups; g++) begin
          if (vmask[g] && votes_r[g] != cmg_pkg::VoteMax) begin
            votes_nxt[g] = votes_r[g] + cmg_pkg::vote_t'(1);
          end
        end
      end
      prev_nxt = {prev_r[7:0], s1_byte_r};
      pos_nxt  = pos_r + pos_t'(1);
    end
  end

  // classifier on the updated state
  logic           ab;
  logic [15:0]    init_n, idx_n;
  cmg_pkg::byte_t probe_n;
  cmg_pkg::vote_t cnt [cmg_pkg::NumGroups];
  logic [cmg_pkg::NumGroups-1:0] win;

  always_comb begin
    ab      = hdr_nxt[7:0] == cmg_pkg::HdrA && hdr_nxt[15:8] == cmg_pkg::HdrB;
    init_n  = hdr_nxt[31:16];
    idx_n   = init_n & size_m1[15:0];
    probe_n = (idx_n < 16'(cmg_pkg::HeaderBytes)) ? hdr_nxt[{idx_n[1:0], 3'b000} +: 8]
                                                 : probe_nxt;
    for (int g = 0; g < cmg_pkg::NumGroups; g++) begin
      cnt[g] = votes_nxt[g];
    end
    // group C is handicapped by one vote
    if (cnt[cmg_pkg::GroupC] != '0) begin
      cnt[cmg_pkg::GroupC] = votes_nxt[cmg_pkg::GroupC] - cmg_pkg::vote_t'(1);
    end
    // winner: the latest group holding the nonzero maximum
    for (int g = 0; g < cmg_pkg::NumGroups; g++) begin
      win[g] = cnt[g] != '0;
      for (int j = 0; j < cmg_pkg::NumGroups; j++) begin
        if (j < g && cnt[g] < cnt[j]) begin
          win[g] = 1'b0;
        end
        if (j > g && cnt[g] <= cnt[j]) begin
          win[g] = 1'b0;
        end
      end
    end

    priority if (size_eff == '0) begin
      class_nxt = cmg_pkg::ClassPlain;
    end else if (size_eff >= PW'(cmg_pkg::SigEnd) && pos_nxt >= PW'(cmg_pkg::SigEnd)
                 && sigm_nxt != '0) begin
      priority if (sigm_nxt[0]) begin
        class_nxt = cmg_pkg::ClassSigA;
      end else if (sigm_nxt[1]) begin
        class_nxt = cmg_pkg::ClassSigB;
      end else begin
        class_nxt = cmg_pkg::ClassSigC;
      end
    end else if (size_eff < PW'(cmg_pkg::FlatSize)) begin
      if (size_eff <= PW'(cmg_pkg::Page2MaxSize) && size_eff >= PW'(cmg_pkg::Page2MinSize)
          && ab && text_nxt[15:14] == 2'b10
          && (init_n == '0 || (init_n[15:14] == 2'b10 && probe_n == cmg_pkg::OpReturn))) begin
        class_nxt = cmg_pkg::ClassPage2;
      end else begin
        class_nxt = cmg_pkg::ClassMirrored;
      end
    end else if (size_eff == PW'(cmg_pkg::FlatSize) && !ab) begin
      class_nxt = cmg_pkg::ClassMirrored;
    end else if (win[cmg_pkg::GroupD]) begin
      class_nxt = cmg_pkg::ClassVoteD;
    end else if (win[cmg_pkg::GroupC]) begin
      class_nxt = cmg_pkg::ClassVoteC;
    end else if (win[cmg_pkg::GroupB]) begin
      class_nxt = cmg_pkg::ClassVoteB;
    end else if (win[cmg_pkg::GroupA]) begin
      class_nxt = cmg_pkg::ClassVoteA;
    end else begin
      class_nxt = cmg_pkg::ClassGeneric8k;
    end
  end

  // stream state; the last byte clears it for the next image
  always_ff @(posedge clk) begin
    if (!rst_n || (take && s1_last_r)) begin
      pos_r   <= '0;
      prev_r  <= '0;
      hdr_r   <= '0;
      text_r  <= '0;
      probe_r <= '0;
      sigm_r  <= '1;
      for (int g = 0; g < cmg_pkg::NumGroups; g++) begin
        votes_r[g] <= '0;
      end
    end else begin
      pos_r   <= pos_nxt;
      prev_r  <= prev_nxt;
      hdr_r   <= hdr_nxt;
      text_r  <= text_nxt;
      probe_r <= probe_nxt;
      sigm_r  <= sigm_nxt;
      for (int g = 0; g < cmg_pkg::NumGroups; g++) begin
        votes_r[g] <= votes_nxt[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= take && s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_class_r <= class_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/cmg_checker.sv
// Port-level checker for the mapper guesser, bound to the top level.
// Depends on cmg_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module cmg_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input cmg_pkg::mapper_class_t mapper_class
);

  logic stalled;
  logic class_ok;

  assign stalled  = out_valid && !out_ready;
  assign class_ok = mapper_class <= cmg_pkg::ClassVoteD;

  // a stalled result stays put
  `ASSERT_RST(a_out_hold, clk, rst_n, stalled |=> out_valid && $stable(mapper_class), "result changed while stalled")

  `ASSERT_RST(a_class_range, clk, rst_n, out_valid |-> class_ok, "class code out of range")

  // no back-pressure on the input unless the result side is stalled
  `ASSERT_ALWAYS(a_in_ready, clk, !stalled |-> in_ready, "input blocked without output stall")

  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result pending after reset")

endmodule

bind cartridge_mapper_guesser cmg_checker u_cmg_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .mapper_class (out_ch.mapper_class)
);

`default_nettype wire
